### rtl/core/dtes_pkg.sv
// shared types, constants and calendar tables for the date to epoch seconds converter
package dtes_pkg;

  // field widths
  localparam int unsigned YearW   = 16;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned EpochW  = 32;

  // internal widths
  localparam int unsigned YoffW   = 7;   // years since the base year, 0..99
  localparam int unsigned MbaseW  = 9;   // days before the month, 0..335
  localparam int unsigned DaysW   = 16;  // days since the base date, 0..36524
  localparam int unsigned TodW    = 17;  // seconds in the day, 0..86399

  // calendar constants
  localparam logic [YearW-1:0] BaseYear    = 16'd2000;
  localparam logic [YearW-1:0] LastYear    = 16'd2099;
  localparam logic [CfgW-1:0]  EarliestRst = 12'd2000;
  localparam logic [HourW-1:0] MaxHour     = 5'd23;
  localparam logic [MinW-1:0]  MaxMinute   = 6'd59;
  localparam logic [SecW-1:0]  MaxSecond   = 6'd59;
  localparam logic [8:0]       DaysPerYear = 9'd365;
  localparam logic [16:0]      SecPerDay   = 17'd86400;
  localparam logic [11:0]      SecPerHour  = 12'd3600;
  localparam logic [5:0]       SecPerMin   = 6'd60;

  // month codes
  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonApr = 4'd4;
  localparam logic [MonthW-1:0] MonMay = 4'd5;
  localparam logic [MonthW-1:0] MonJun = 4'd6;
  localparam logic [MonthW-1:0] MonJul = 4'd7;
  localparam logic [MonthW-1:0] MonAug = 4'd8;
  localparam logic [MonthW-1:0] MonSep = 4'd9;
  localparam logic [MonthW-1:0] MonOct = 4'd10;
  localparam logic [MonthW-1:0] MonNov = 4'd11;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  // result of the date check stage
  typedef struct packed {
    logic              ok;
    logic [YoffW-1:0]  yoff;
    logic [MbaseW-1:0] mbase;
    logic [DayW-1:0]   day0;
  } dtes_chk_t;

  // length of a month, leap flag applied to february
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    case (m)
      MonFeb:                        len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default:                       len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of the month, common year
  function automatic logic [MbaseW-1:0] month_base(input logic [MonthW-1:0] m);
    logic [MbaseW-1:0] b;
    b = '0;
    case (m)
      MonJan:  b = 9'd0;
      MonFeb:  b = 9'd31;
      MonMar:  b = 9'd59;
      MonApr:  b = 9'd90;
      MonMay:  b = 9'd120;
      MonJun:  b = 9'd151;
      MonJul:  b = 9'd181;
      MonAug:  b = 9'd212;
      MonSep:  b = 9'd243;
      MonOct:  b = 9'd273;
      MonNov:  b = 9'd304;
      MonDec:  b = 9'd334;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/dtes_if.sv
// request and result channel interfaces of the date to epoch seconds converter
interface dtes_date_if;
  logic                          valid;
  logic                          ready;
  logic [dtes_pkg::YearW-1:0]    calendar_year;
  logic [dtes_pkg::MonthW-1:0]   month_number;
  logic [dtes_pkg::DayW-1:0]     day_of_month;
  logic [dtes_pkg::HourW-1:0]    hour_of_day;
  logic [dtes_pkg::MinW-1:0]     minute_of_hour;
  logic [dtes_pkg::SecW-1:0]     second_of_minute;

  modport source (output valid, calendar_year, month_number, day_of_month,
                  hour_of_day, minute_of_hour, second_of_minute,
                  input ready);
  modport sink   (input valid, calendar_year, month_number, day_of_month,
                  hour_of_day, minute_of_hour, second_of_minute,
                  output ready);
endinterface

interface dtes_seconds_if;
  logic                         valid;
  logic                         ready;
  logic [dtes_pkg::EpochW-1:0]  epoch_seconds;
  logic                         date_valid;

  modport source (output valid, epoch_seconds, date_valid, input ready);
  modport sink   (input valid, epoch_seconds, date_valid, output ready);
endinterface

### rtl/core/dtes_date_check.sv
// field range checks and day-of-year base for one date request
module dtes_date_check (
  input  logic [dtes_pkg::CfgW-1:0]   earliest_year,
  input  logic [dtes_pkg::YearW-1:0]  calendar_year,
  input  logic [dtes_pkg::MonthW-1:0] month_number,
  input  logic [dtes_pkg::DayW-1:0]   day_of_month,
  input  logic [dtes_pkg::HourW-1:0]  hour_of_day,
  input  logic [dtes_pkg::MinW-1:0]   minute_of_hour,
  input  logic [dtes_pkg::SecW-1:0]   second_of_minute,
  output dtes_pkg::dtes_chk_t         chk
);

  logic                          year_ok;
  logic                          month_ok;
  logic                          day_ok;
  logic                          time_ok;
  logic                          leap;
  logic [dtes_pkg::YearW-1:0]    yoff_full;
  logic [dtes_pkg::DayW-1:0]     mlen;

  // within 2000..2099 a year is leap exactly when divisible by four
  assign leap = (calendar_year[1:0] == 2'b00);

  // year window: configured floor, base year and last year
  assign year_ok = (calendar_year >= {{(dtes_pkg::YearW-dtes_pkg::CfgW){1'b0}}, earliest_year})
                && (calendar_year >= dtes_pkg::BaseYear)
                && (calendar_year <= dtes_pkg::LastYear);

  assign month_ok = month_number inside {[dtes_pkg::MonJan:dtes_pkg::MonDec]};

  // day against the month length
  assign mlen   = dtes_pkg::month_length(month_number, leap);
  assign day_ok = (day_of_month != '0) && (day_of_month <= mlen);

  assign time_ok = (hour_of_day <= dtes_pkg::MaxHour)
                && (minute_of_hour <= dtes_pkg::MaxMinute)
                && (second_of_minute <= dtes_pkg::MaxSecond);

  assign yoff_full = calendar_year - dtes_pkg::BaseYear;

  // pack the check result, leap day folded into the month base
  always_comb begin
    chk.ok    = year_ok && month_ok && day_ok && time_ok;
    chk.yoff  = yoff_full[dtes_pkg::YoffW-1:0];
    chk.mbase = dtes_pkg::month_base(month_number)
              + {{(dtes_pkg::MbaseW-1){1'b0}}, (leap && (month_number > dtes_pkg::MonFeb))};
    chk.day0  = day_of_month - 5'd1;
  end

endmodule

### rtl/core/datetime_to_epoch_seconds.sv
// top level: calendar date and time of day to seconds since 2000-01-01 00:00:00
//
//  channel   dir  handshake              payload
//  date      in   date.valid/date.ready  calendar_year .. second_of_minute
//  seconds   out  seconds.valid/ready    epoch_seconds, date_valid
//  cfg       in   cfg_we                 cfg_wdata = earliest_year
//
// three register stages: date check, day count and time of day, seconds product
// one request per cycle sustained while seconds.ready is high; each result is registered
// through stages a, b and c in turn before it is offered on the seconds channel
// the stage-3 multiply (days by 86400) sets the longest path
// each stage holds while the stage after it is full and stalled; bubbles collapse
// rst clears the stage valid bits and sets earliest_year to 2000
module datetime_to_epoch_seconds (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dtes_pkg::CfgW-1:0] cfg_wdata,
  dtes_date_if.sink                 date,
  dtes_seconds_if.source            seconds
);

  logic [dtes_pkg::CfgW-1:0]    earliest_year;
  dtes_pkg::dtes_chk_t          chk_in;

  // stage a: check result and time fields
  logic                         a_valid;
  dtes_pkg::dtes_chk_t          a_chk;
  logic [dtes_pkg::HourW-1:0]   a_hour;
  logic [dtes_pkg::MinW-1:0]    a_min;
  logic [dtes_pkg::SecW-1:0]    a_sec;

  // stage b: day count and seconds in the day
  logic                         b_valid;
  logic                         b_ok;
  logic [dtes_pkg::DaysW-1:0]   b_days;
  logic [dtes_pkg::TodW-1:0]    b_tod;
  logic [dtes_pkg::DaysW-1:0]   days_next;
  logic [dtes_pkg::TodW-1:0]    tod_next;

  // stage c: output register
  logic                         c_valid;
  logic [dtes_pkg::EpochW-1:0]  c_secs;
  logic                         c_ok;
  logic [dtes_pkg::DaysW+dtes_pkg::TodW-1:0] prod;
  logic [dtes_pkg::EpochW-1:0]  secs_next;

  logic a_load, b_load, c_load;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      earliest_year <= dtes_pkg::EarliestRst;
    end else if (cfg_we) begin
      earliest_year <= cfg_wdata;
    end
  end

  // stage load enables, each stage moves when the next has room
  assign c_load     = !c_valid || seconds.ready;
  assign b_load     = !b_valid || c_load;
  assign a_load     = !a_valid || b_load;
  assign date.ready = a_load;

  dtes_date_check u_check (
    .earliest_year    (earliest_year),
    .calendar_year    (date.calendar_year),
    .month_number     (date.month_number),
    .day_of_month     (date.day_of_month),
    .hour_of_day      (date.hour_of_day),
    .minute_of_hour   (date.minute_of_hour),
    .second_of_minute (date.second_of_minute),
    .chk              (chk_in)
  );

  // stage a registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= date.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && date.valid) begin
      a_chk  <= chk_in;
      a_hour <= date.hour_of_day;
      a_min  <= date.minute_of_hour;
      a_sec  <= date.second_of_minute;
    end
  end

  // day count: whole years, leap days before the year, month base, day
  always_comb begin
    days_next = dtes_pkg::DaysW'(a_chk.yoff * dtes_pkg::DaysPerYear)
              + dtes_pkg::DaysW'((a_chk.yoff + 7'd3) >> 2)
              + dtes_pkg::DaysW'(a_chk.mbase)
              + dtes_pkg::DaysW'(a_chk.day0);
    tod_next  = dtes_pkg::TodW'(a_hour * dtes_pkg::SecPerHour)
              + dtes_pkg::TodW'(a_min * dtes_pkg::SecPerMin)
              + dtes_pkg::TodW'(a_sec);
  end

  // stage b registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      b_ok   <= a_chk.ok;
      b_days <= days_next;
      b_tod  <= tod_next;
    end
  end

  // seconds product, forced to zero for a rejected date
  assign prod      = b_days * dtes_pkg::SecPerDay;
  assign secs_next = b_ok ? (prod[dtes_pkg::EpochW-1:0]
                             + {{(dtes_pkg::EpochW-dtes_pkg::TodW){1'b0}}, b_tod})
                          : '0;

  // stage c registers
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_load) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load && b_valid) begin
      c_secs <= secs_next;
      c_ok   <= b_ok;
    end
  end

  assign seconds.valid         = c_valid;
  assign seconds.epoch_seconds = c_secs;
  assign seconds.date_valid    = c_ok;

endmodule

### rtl/core/dtes_checker.sv
// port-level assertions for the date to epoch seconds converter, bound to the top level
module dtes_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dtes_pkg::EpochW-1:0] epoch_seconds,
  input logic                        date_valid
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(epoch_seconds) && $stable(date_valid))
    else $error("stalled result changed");

  // a rejected date carries zero seconds
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !date_valid |-> epoch_seconds == '0)
    else $error("rejected date with nonzero seconds");

  // nothing past 2099-12-31 23:59:59
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid |-> epoch_seconds <= 32'd3155759999)
    else $error("seconds beyond the last accepted year");

  // pipeline is empty right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind datetime_to_epoch_seconds dtes_checker u_dtes_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (seconds.valid),
  .out_ready     (seconds.ready),
  .epoch_seconds (seconds.epoch_seconds),
  .date_valid    (seconds.date_valid)
);
